>>> rtl/core/utf8sd_pkg.sv
// shared types, constants and lead byte classification for the utf-8 stream decoder
`default_nettype none
package utf8sd_pkg;

    localparam int CP_W      = 31;
    localparam int MIN_W     = 27;
    localparam int LEFT_W    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0]   REPL_CP  = 31'h0000_FFFD;
    localparam logic [MIN_W-1:0]  MIN_2B   = 27'h000_0080;
    localparam logic [MIN_W-1:0]  MIN_3B   = 27'h000_0800;
    localparam logic [MIN_W-1:0]  MIN_4B   = 27'h001_0000;
    localparam logic [MIN_W-1:0]  MIN_5B   = 27'h020_0000;
    localparam logic [MIN_W-1:0]  MIN_6B   = 27'h400_0000;

    // one decoded result beat
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            last;
    } t_result;

    // one queue entry: the results caused by one input byte
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // outcome of a byte handled with no sequence open
    typedef struct packed {
        logic              emit;
        logic              repl;
        logic [CP_W-1:0]   cp;
        logic              opens;
        logic [LEFT_W-1:0] left;
        logic [CP_W-1:0]   partial;
        logic [MIN_W-1:0]  minv;
    } t_lead;

    function automatic t_lead take_lead(input logic [7:0] b);
        t_lead l;
        l = '0;
        case (b) inside
            [8'h00:8'h7F]: begin
                l.emit = 1'b1;
                l.cp   = {{(CP_W-8){1'b0}}, b};
            end
            [8'hC0:8'hDF]: begin
                l.opens   = 1'b1;
                l.left    = 3'd1;
                l.partial = {{(CP_W-5){1'b0}}, b[4:0]};
                l.minv    = MIN_2B;
            end
            [8'hE0:8'hEF]: begin
                l.opens   = 1'b1;
                l.left    = 3'd2;
                l.partial = {{(CP_W-4){1'b0}}, b[3:0]};
                l.minv    = MIN_3B;
            end
            [8'hF0:8'hF7]: begin
                l.opens   = 1'b1;
                l.left    = 3'd3;
                l.partial = {{(CP_W-3){1'b0}}, b[2:0]};
                l.minv    = MIN_4B;
            end
            [8'hF8:8'hFB]: begin
                l.opens   = 1'b1;
                l.left    = 3'd4;
                l.partial = {{(CP_W-2){1'b0}}, b[1:0]};
                l.minv    = MIN_5B;
            end
            [8'hFC:8'hFD]: begin
                l.opens   = 1'b1;
                l.left    = 3'd5;
                l.partial = {{(CP_W-1){1'b0}}, b[0]};
                l.minv    = MIN_6B;
            end
            default: begin
                // stray continuation byte, 0xfe or 0xff
                l.emit = 1'b1;
                l.repl = 1'b1;
                l.cp   = REPL_CP;
            end
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/utf8sd_front.sv
// front end: accepts bytes, runs the sequence state and forms result entries
`default_nettype none
module utf8sd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_byte_in,
    input  wire utf8sd_pkg::t_qstat   i_qstat,
    output logic                      o_push,
    output utf8sd_pkg::t_entry        o_entry
);

    logic [utf8sd_pkg::CP_W-1:0]   r_partial, n_partial;
    logic [utf8sd_pkg::LEFT_W-1:0] r_left,    n_left;
    logic [utf8sd_pkg::MIN_W-1:0]  r_min,     n_min;

    logic                          accept;
    utf8sd_pkg::t_lead             lead;
    logic [utf8sd_pkg::CP_W-1:0]   shifted;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign lead    = utf8sd_pkg::take_lead(i_byte_in);
    assign shifted = {r_partial[utf8sd_pkg::CP_W-7:0], i_byte_in[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_min     = r_min;
        o_push    = 1'b0;
        o_entry   = '0;
        if (accept) begin
            if (r_left == '0) begin
                if (lead.opens) begin
                    n_partial = lead.partial;
                    n_left    = lead.left;
                    n_min     = lead.minv;
                end
                o_push        = lead.emit;
                o_entry.r0.cp   = lead.cp;
                o_entry.r0.repl = lead.repl;
                o_entry.r0.last = 1'b1;
            end else if (i_byte_in[7:6] == 2'b10) begin
                n_partial = shifted;
                n_left    = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    o_push = 1'b1;
                    o_entry.r0.last = 1'b1;
                    // overlong completion
                    if (shifted < {{(utf8sd_pkg::CP_W-utf8sd_pkg::MIN_W){1'b0}}, r_min}) begin
                        o_entry.r0.cp   = utf8sd_pkg::REPL_CP;
                        o_entry.r0.repl = 1'b1;
                    end else begin
                        o_entry.r0.cp   = shifted;
                    end
                end
            end else begin
                // broken sequence: replacement, then the byte again as a lead
                n_left = '0;
                if (lead.opens) begin
                    n_partial = lead.partial;
                    n_left    = lead.left;
                    n_min     = lead.minv;
                end
                o_push          = 1'b1;
                o_entry.two     = lead.emit;
                o_entry.r0.cp   = utf8sd_pkg::REPL_CP;
                o_entry.r0.repl = 1'b1;
                o_entry.r0.last = !lead.emit;
                o_entry.r1.cp   = lead.cp;
                o_entry.r1.repl = lead.repl;
                o_entry.r1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= '0;
            r_min     <= '0;
        end else begin
            r_partial <= n_partial;
            r_left    <= n_left;
            r_min     <= n_min;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'd5)
        else $error("continuation count out of range");

    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("entry pushed without an accepted byte");

endmodule
`default_nettype wire

>>> rtl/core/utf8sd_queue.sv
// short entry queue between front and back
`default_nettype none
module utf8sd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire utf8sd_pkg::t_entry   i_entry,
    input  wire logic                 i_pop,
    output utf8sd_pkg::t_entry        o_head,
    output utf8sd_pkg::t_qstat        o_qstat
);

    utf8sd_pkg::t_entry                r_mem [utf8sd_pkg::QUEUE_DEPTH];
    logic [utf8sd_pkg::QUEUE_AW-1:0]   r_wr, n_wr;
    logic [utf8sd_pkg::QUEUE_AW-1:0]   r_rd, n_rd;
    logic [utf8sd_pkg::QUEUE_CW-1:0]   r_count, n_count;

    assign o_qstat.full  = (r_count == utf8sd_pkg::QUEUE_CW'(utf8sd_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr + (i_push ? 1'b1 : 1'b0);
        n_rd    = r_rd + (i_pop ? 1'b1 : 1'b0);
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= utf8sd_pkg::QUEUE_CW'(utf8sd_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> rtl/core/utf8sd_back.sv
// back end: drains queue entries one result beat at a time into the output register
`default_nettype none
module utf8sd_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire utf8sd_pkg::t_entry   i_head,
    input  wire utf8sd_pkg::t_qstat   i_qstat,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output utf8sd_pkg::t_result       o_result
);

    logic                 r_valid, n_valid;
    logic                 r_second, n_second;
    utf8sd_pkg::t_result  r_result, n_result;
    logic                 load;

    assign load     = (!r_valid || !i_stall) && !i_qstat.empty;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid  = r_valid && i_stall;
        n_second = r_second;
        n_result = r_result;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (r_second) begin
                n_result = i_head.r1;
                n_second = 1'b0;
                o_pop    = 1'b1;
            end else begin
                n_result = i_head.r0;
                n_second = i_head.two;
                o_pop    = !i_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    a_second_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !i_qstat.empty)
        else $error("second result pending with empty queue");

endmodule
`default_nettype wire

>>> rtl/core/utf8_stream_decoder.sv
// top level of the utf-8 to 31-bit code point stream decoder
// usage:
//   input channel: one byte per beat on i_byte_in, i_valid high, o_stall low
//   output channel: one code point per beat, o_valid high, i_stall low
//   each byte gives zero, one or two result beats; o_last_of_run marks the
//   final beat caused by a byte, o_is_replacement marks error substitutes
//   (0xfffd for stray bytes, 0xfe/0xff, broken or overlong sequences)
//   a result is registered first in the queue and then in the output register
//   throughput: one byte per cycle while o_stall is low; each result of a byte
//   takes its own beat in the single output register draining the queue
//   the front decoder and back output stage are parted by a four-entry queue,
//   so bytes keep flowing while the receiver holds a finished result
//   receiver stall: the output beat holds; once the queue fills, o_stall rises
//   reset (i_rst_n low, synchronous): no sequence open, queue empty, o_valid low
`default_nettype none
module utf8_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [30:0]      o_code_point,
    output logic             o_is_replacement,
    output logic             o_last_of_run
);

    // front to queue
    logic                 push;
    utf8sd_pkg::t_entry   push_entry;
    // queue to back
    logic                 pop;
    utf8sd_pkg::t_entry   head;
    utf8sd_pkg::t_qstat   qstat;
    // output register contents
    utf8sd_pkg::t_result  result;

    // sequence state and per-byte classification
    utf8sd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_byte_in (i_byte_in),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // decouples decoding from the receiver's stalls
    utf8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // splits two-result entries into beats
    utf8sd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    assign o_code_point     = result.cp;
    assign o_is_replacement = result.repl;
    assign o_last_of_run    = result.last;

endmodule
`default_nettype wire
